// File: rtl/core/afrp_pkg.sv
// Package for the API frame receive parser.
// Holds the parse phase type, the frame constants and the result beat type.
// Depends on nothing.
package afrp_pkg;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_API     = 3'd3,
        PH_HEADER  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } t_phase;

    // Header field positions after the API id.
    typedef enum logic [1:0] {
        HDR_SRC_HI  = 2'd0,
        HDR_SRC_LO  = 2'd1,
        HDR_RSSI    = 2'd2,
        HDR_OPTIONS = 2'd3
    } t_hdr_idx;

    localparam logic [7:0]  START_BYTE = 8'h7E;
    localparam logic [7:0]  RX16_ID    = 8'h81;
    localparam logic [7:0]  SUM_BASE   = 8'hFF;
    localparam logic [15:0] HEADER_LEN = 16'd5;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] source_addr;
        logic [7:0]  signal_strength;
        logic        is_end;
        logic        checksum_ok;
    } t_result;

endpackage

// File: rtl/core/afrp_front.sv
// Front part of the API frame receive parser: per-byte frame state machine.
// Classifies each received beat and builds at most one result beat from it.
// Depends on afrp_pkg.
module afrp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output afrp_pkg::t_result o_res
);

    afrp_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_len_hi, n_len_hi;
    logic [1:0]       r_hdr_idx, n_hdr_idx;
    logic [15:0]      r_bytes_left, n_bytes_left;
    logic [7:0]       r_sum, n_sum;
    logic [15:0]      r_source, n_source;
    logic [7:0]       r_strength, n_strength;

    logic [15:0] len_full;
    logic [15:0] bytes_dec;

    assign len_full  = {r_len_hi, i_byte};
    assign bytes_dec = (r_bytes_left != 16'd0) ? (r_bytes_left - 16'd1) : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= afrp_pkg::PH_HUNT;
            r_len_hi     <= 8'd0;
            r_hdr_idx    <= 2'd0;
            r_bytes_left <= 16'd0;
            r_sum        <= 8'd0;
            r_source     <= 16'd0;
            r_strength   <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_len_hi     <= n_len_hi;
            r_hdr_idx    <= n_hdr_idx;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_source     <= n_source;
            r_strength   <= n_strength;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_len_hi     = r_len_hi;
        n_hdr_idx    = r_hdr_idx;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_source     = r_source;
        n_strength   = r_strength;

        o_res_valid           = 1'b0;
        o_res.data_byte       = i_byte;
        o_res.source_addr     = r_source;
        o_res.signal_strength = r_strength;
        o_res.is_end          = 1'b0;
        o_res.checksum_ok     = 1'b0;

        if (i_valid) begin
            case (r_phase)
                afrp_pkg::PH_LEN_HI: begin
                    n_len_hi = i_byte;
                    n_phase  = afrp_pkg::PH_LEN_LO;
                end
                afrp_pkg::PH_LEN_LO: begin
                    n_bytes_left = (len_full < afrp_pkg::HEADER_LEN) ? 16'd0 :
                                   (len_full - afrp_pkg::HEADER_LEN);
                    n_phase      = afrp_pkg::PH_API;
                end
                afrp_pkg::PH_API: begin
                    if (i_byte == afrp_pkg::RX16_ID) begin
                        n_sum     = i_byte;
                        n_hdr_idx = 2'd0;
                        n_phase   = afrp_pkg::PH_HEADER;
                    end else begin
                        n_phase = afrp_pkg::PH_HUNT;
                    end
                end
                afrp_pkg::PH_HEADER: begin
                    n_sum = r_sum + i_byte;
                    case (afrp_pkg::t_hdr_idx'(r_hdr_idx))
                        afrp_pkg::HDR_SRC_HI: n_source = {i_byte, r_source[7:0]};
                        afrp_pkg::HDR_SRC_LO: n_source = {r_source[15:8], i_byte};
                        afrp_pkg::HDR_RSSI:   n_strength = i_byte;
                        default: ;
                    endcase
                    if (r_hdr_idx == afrp_pkg::HDR_OPTIONS) begin
                        n_hdr_idx = 2'd0;
                        n_phase   = (r_bytes_left == 16'd0) ? afrp_pkg::PH_CHECK :
                                                              afrp_pkg::PH_PAYLOAD;
                    end else begin
                        n_hdr_idx = r_hdr_idx + 2'd1;
                    end
                end
                afrp_pkg::PH_PAYLOAD: begin
                    n_sum        = r_sum + i_byte;
                    o_res_valid  = 1'b1;
                    n_bytes_left = bytes_dec;
                    if (bytes_dec == 16'd0) begin
                        n_phase = afrp_pkg::PH_CHECK;
                    end
                end
                afrp_pkg::PH_CHECK: begin
                    o_res_valid       = 1'b1;
                    o_res.data_byte   = 8'd0;
                    o_res.is_end      = 1'b1;
                    o_res.checksum_ok = ((afrp_pkg::SUM_BASE - r_sum) == i_byte);
                    n_phase           = afrp_pkg::PH_HUNT;
                end
                default: begin
                    // Hunting, and the unused phase code as well.
                    n_phase = (i_byte == afrp_pkg::START_BYTE) ? afrp_pkg::PH_LEN_HI :
                                                                 afrp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // The payload phase is only entered with bytes left and is left when none remain.
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == afrp_pkg::PH_PAYLOAD |-> r_bytes_left != 16'd0)
        else $error("payload phase with no payload bytes left");

    // An end beat comes only from the checksum phase, so the phase returns to hunting.
    a_end_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.is_end |=> r_phase == afrp_pkg::PH_HUNT)
        else $error("parser did not return to hunting after the end beat");

endmodule

// File: rtl/core/afrp_fifo.sv
// Back part of the API frame receive parser: a short result queue.
// Stores result beats from the front part and presents the oldest one.
// Depends on afrp_pkg.
module afrp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  afrp_pkg::t_result i_wr_data,
    input  logic              i_rd,
    output afrp_pkg::t_result o_rd_data,
    output logic              o_empty,
    output logic              o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    afrp_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              do_wr, do_rd;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == FULL_CNT);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue fill count beyond its depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_wr && !do_rd |=> r_count == $past(r_count) + CW'(1))
        else $error("queue fill count missed a write");

endmodule

// File: rtl/core/api_frame_receive_parser.sv
// Top level of the API frame receive parser.
// Instantiates the front parser (afrp_front) and the result queue (afrp_fifo).
// Depends on afrp_pkg, afrp_front and afrp_fifo.

// The parser takes one received serial byte per beat and accepts a byte in
// every clock cycle while full is low. It hunts for the start byte 0x7E, reads
// the two length bytes and the API id, and keeps only frames with id 0x81;
// any other id sends it back to hunting. After the source address, signal
// strength and options bytes it streams out length minus five payload beats,
// each tagged with the frame's source address and signal strength, and then
// one end beat whose checksum_ok tells whether 0xFF minus the 8-bit sum from
// the API id through the last payload byte equals the checksum byte. A length
// below five gives an empty payload. Header and length bytes yield no result.
// The whole per-byte frame state is registered for each byte taken, so the
// sustained rate is one byte per cycle while full is low. A result is
// written into a queue of QUEUE_DEPTH entries on the same edge at which its
// byte is taken; if the queue was empty, it is on the result ports from the
// next cycle. full rises only when that queue is full, as results outpace pop.
module api_frame_receive_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_source_addr,
    output logic [7:0]  o_signal_strength,
    output logic        o_is_end,
    output logic        o_checksum_ok
);

    logic              accept;
    logic              res_valid;
    afrp_pkg::t_result res;
    afrp_pkg::t_result head;

    // A byte beat is taken only while the queue has room for its result.
    assign accept = push && !full;

    afrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_byte      (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    afrp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_valid),
        .i_wr_data (res),
        .i_rd      (pop),
        .o_rd_data (head),
        .o_empty   (empty),
        .o_full    (full)
    );

    assign o_data_byte       = head.data_byte;
    assign o_source_addr     = head.source_addr;
    assign o_signal_strength = head.signal_strength;
    assign o_is_end          = head.is_end;
    assign o_checksum_ok     = head.checksum_ok;

endmodule

// File: dv/tb.sv
// Testbench for the API frame receive parser (api_frame_receive_parser).
// It drives random and directed serial byte streams, checks each result beat
// against its own frame parser, and depends on afrp_pkg and the RTL only.
`timescale 1ns / 1ps

module tb;

    // Bytes taken by the block, hunting noise included, after which the random stream stops.
    localparam int unsigned BYTE_TARGET  = 1950;
    localparam int unsigned LIMIT_CYCLES = 400_000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_rx_byte;
    logic        empty;
    logic        pop;
    logic [7:0]  o_data_byte;
    logic [15:0] o_source_addr;
    logic [7:0]  o_signal_strength;
    logic        o_is_end;
    logic        o_checksum_ok;

    api_frame_receive_parser u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_rx_byte         (i_rx_byte),
        .empty             (empty),
        .pop               (pop),
        .o_data_byte       (o_data_byte),
        .o_source_addr     (o_source_addr),
        .o_signal_strength (o_signal_strength),
        .o_is_end          (o_is_end),
        .o_checksum_ok     (o_checksum_ok)
    );

    // Beats that the frame parser below says must come out, oldest first.
    afrp_pkg::t_result pending_beats[$];

    // Our own copy of the parser state.
    afrp_pkg::t_phase   pst_phase;
    afrp_pkg::t_hdr_idx pst_hdr;
    logic [7:0]         pst_len_hi;
    logic [15:0]        pst_left;
    logic [7:0]         pst_sum;
    logic [15:0]        pst_src;
    logic [7:0]         pst_rssi;

    // Idle percentages of the two sides, and a hold-off request that the
    // receiving process turns into a run of cycles with pop held low.
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned rx_hold_req;

    // Statistics and error bookkeeping.
    int unsigned sent_bytes;
    int unsigned parsed_bytes;
    int unsigned stall_cycles;
    int unsigned payload_beats;
    int unsigned end_beats;
    int unsigned good_end_beats;
    int unsigned error_count;

    // 50 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give up if the run hangs. The budget is many times the slowest run
    // that a correct parser could need.
    initial begin
        #(LIMIT_CYCLES * 20);
        $display("Timeout with %0d beats still expected.", pending_beats.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Walk one accepted byte through the frame parser and queue whatever
    // result beat it causes. This mirrors the per-byte state update of the
    // block: hunt, two length bytes, API id, four header bytes, payload, and
    // the checksum byte.
    task automatic parse_rx_byte(input logic [7:0] b);
        afrp_pkg::t_result beat;
        logic [15:0]       len;
        beat = '0;
        if (pst_phase != afrp_pkg::PH_HUNT || b == afrp_pkg::START_BYTE) begin
            parsed_bytes++;
        end
        case (pst_phase)
            afrp_pkg::PH_LEN_HI: begin
                pst_len_hi = b;
                pst_phase  = afrp_pkg::PH_LEN_LO;
            end
            afrp_pkg::PH_LEN_LO: begin
                len = {pst_len_hi, b};
                // A length that cannot even hold the header means no payload.
                pst_left  = (len < afrp_pkg::HEADER_LEN) ? 16'd0 :
                                                           len - afrp_pkg::HEADER_LEN;
                pst_phase = afrp_pkg::PH_API;
            end
            afrp_pkg::PH_API: begin
                if (b == afrp_pkg::RX16_ID) begin
                    pst_sum   = b;
                    pst_hdr   = afrp_pkg::HDR_SRC_HI;
                    pst_phase = afrp_pkg::PH_HEADER;
                end else begin
                    pst_phase = afrp_pkg::PH_HUNT;
                end
            end
            afrp_pkg::PH_HEADER: begin
                pst_sum = pst_sum + b;
                case (pst_hdr)
                    afrp_pkg::HDR_SRC_HI: pst_src[15:8] = b;
                    afrp_pkg::HDR_SRC_LO: pst_src[7:0]  = b;
                    afrp_pkg::HDR_RSSI:   pst_rssi      = b;
                    default:    ;
                endcase
                if (pst_hdr == afrp_pkg::HDR_OPTIONS) begin
                    pst_hdr   = afrp_pkg::HDR_SRC_HI;
                    pst_phase = (pst_left == 16'd0) ? afrp_pkg::PH_CHECK :
                                                      afrp_pkg::PH_PAYLOAD;
                end else begin
                    pst_hdr = afrp_pkg::t_hdr_idx'(pst_hdr + 2'd1);
                end
            end
            afrp_pkg::PH_PAYLOAD: begin
                pst_sum              = pst_sum + b;
                beat.data_byte       = b;
                beat.source_addr     = pst_src;
                beat.signal_strength = pst_rssi;
                pending_beats.push_back(beat);
                pst_left = pst_left - 16'd1;
                if (pst_left == 16'd0) begin
                    pst_phase = afrp_pkg::PH_CHECK;
                end
            end
            afrp_pkg::PH_CHECK: begin
                beat.source_addr     = pst_src;
                beat.signal_strength = pst_rssi;
                beat.is_end          = 1'b1;
                beat.checksum_ok     = ((afrp_pkg::SUM_BASE - pst_sum) == b);
                pending_beats.push_back(beat);
                pst_phase = afrp_pkg::PH_HUNT;
            end
            default: begin
                // Hunting, and any unused phase code, look for the start byte.
                pst_phase = (b == afrp_pkg::START_BYTE) ? afrp_pkg::PH_LEN_HI :
                                                          afrp_pkg::PH_HUNT;
            end
        endcase
    endtask

    // Offer one byte and wait until the block takes it. Every call starts and
    // ends at a falling edge, so push gets exactly one assignment per edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) begin
            stall_cycles++;
            @(posedge i_clk);
        end
        sent_bytes++;
        parse_rx_byte(b);
        @(negedge i_clk);
    endtask

    // Stop offering bytes until every expected beat has come out.
    task automatic wait_drain();
        push <= 1'b0;
        while (pending_beats.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Send one frame. fill below zero means random payload bytes, otherwise
    // every payload byte takes that value. cut below zero sends the whole
    // frame, otherwise only its first cut bytes go out.
    task automatic send_frame(input logic [15:0] len_field, input logic [7:0] api_id,
                              input logic [15:0] src, input logic [7:0] rssi,
                              input logic [7:0] opts, input int fill,
                              input bit cks_good, input int cut);
        logic [7:0]  frame_bytes[$];
        logic [7:0]  sum;
        logic [7:0]  pb;
        int unsigned n_payload;
        int          n_send;
        n_payload = (len_field < afrp_pkg::HEADER_LEN) ? 0 :
                                                         len_field - afrp_pkg::HEADER_LEN;
        frame_bytes = '{afrp_pkg::START_BYTE, len_field[15:8], len_field[7:0], api_id,
                        src[15:8], src[7:0], rssi, opts};
        sum = api_id + src[15:8] + src[7:0] + rssi + opts;
        for (int unsigned i = 0; i < n_payload; i++) begin
            pb = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum = sum + pb;
            frame_bytes.push_back(pb);
        end
        pb = afrp_pkg::SUM_BASE - sum;
        if (!cks_good) begin
            pb = pb ^ 8'($urandom_range(1, 255));
        end
        frame_bytes.push_back(pb);
        n_send = (cut < 0 || cut > frame_bytes.size()) ? frame_bytes.size() : cut;
        for (int i = 0; i < n_send; i++) begin
            send_byte(frame_bytes[i]);
        end
    endtask

    // A well-formed frame with random content. Most payloads are short; a
    // few are longer, and some length fields are too short to hold a header.
    // A truncated frame leaves the parser mid-frame so the next frame's
    // bytes are taken as data.
    task automatic send_random_frame(input bit allow_cut);
        logic [15:0] len;
        int unsigned pick;
        int          cut;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            len = 16'($urandom_range(0, 5));
        end else if (pick < 95) begin
            len = 16'(5 + $urandom_range(1, 20));
        end else begin
            len = 16'(5 + $urandom_range(30, 60));
        end
        cut = -1;
        if (allow_cut && $urandom_range(0, 99) < 12) begin
            cut = $urandom_range(1, 8 + int'(len));
        end
        send_frame(len, afrp_pkg::RX16_ID, 16'($urandom), 8'($urandom), 8'($urandom),
                   -1, $urandom_range(0, 99) < 75, cut);
    endtask

    // Short hand-picked stream: bytes dropped while hunting, all-ones header
    // fields with a start byte inside the payload and a good checksum, a
    // wrong API id, and a short length field with zero fields and a bad
    // checksum.
    task automatic test_directed_frames();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'd6, afrp_pkg::RX16_ID, 16'hFFFF, 8'hFF, 8'hFF,
                   afrp_pkg::START_BYTE, 1'b1, -1);
        send_frame(16'd6, 8'h80, 16'h0000, 8'h00, 8'h00, -1, 1'b1, 4);
        send_frame(16'd3, afrp_pkg::RX16_ID, 16'h0000, 8'h00, 8'h00, -1, 1'b0, -1);
        wait_drain();
    endtask

    // Neither side idles, so the parser runs at one byte per cycle.
    task automatic test_back_to_back();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (15) begin
            send_random_frame(1'b0);
        end
        wait_drain();
        src_idle_pct  = 28;
        sink_idle_pct = 28;
    endtask

    // The receiver holds off while a frame with a length high byte set
    // streams in, so the result queue fills and full pushes back on the
    // sender. Then the sender waits for everything to come out.
    task automatic test_backpressure();
        src_idle_pct = 0;
        rx_hold_req  = 150;
        send_frame(16'h0105, afrp_pkg::RX16_ID, 16'($urandom), 8'($urandom),
                   8'($urandom), -1, 1'b1, -1);
        wait_drain();
        src_idle_pct = 28;
    endtask

    // Mostly well-formed frames with random content, mixed with line noise,
    // frames with a wrong API id and truncated frames.
    task automatic test_random_stream();
        int unsigned pick;
        logic [7:0]  bad_id;
        while (sent_bytes < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                send_random_frame(1'b1);
            end else if (pick < 87) begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom));
                end
            end else begin
                bad_id = 8'($urandom);
                if (bad_id == afrp_pkg::RX16_ID) begin
                    bad_id = ~bad_id;
                end
                send_frame(16'(5 + $urandom_range(0, 6)), bad_id, 16'($urandom),
                           8'($urandom), 8'($urandom), -1, 1'b1, -1);
            end
        end
        wait_drain();
    endtask

    // Receiving side: pop changes only at falling edges. A hold-off request
    // is counted down here, one cycle at a time.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Compare every popped beat with the oldest expected one.
    always @(posedge i_clk) begin
        afrp_pkg::t_result got;
        afrp_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            got = '{o_data_byte, o_source_addr, o_signal_strength, o_is_end,
                    o_checksum_ok};
            if (o_is_end) begin
                end_beats++;
                if (o_checksum_ok) begin
                    good_end_beats++;
                end
            end else begin
                payload_beats++;
            end
            if (pending_beats.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%t: beat with nothing expected: data %h src %h rssi %h %s",
                             $realtime, got.data_byte, got.source_addr,
                             got.signal_strength,
                             $sformatf("end %b ok %b", got.is_end, got.checksum_ok));
                end
            end else begin
                want = pending_beats.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%t: mismatch, expected data %h src %h rssi %h end %b ok %b",
                                 $realtime, want.data_byte, want.source_addr,
                                 want.signal_strength, want.is_end, want.checksum_ok);
                        $display("%t:            got data %h src %h rssi %h end %b ok %b",
                                 $realtime, got.data_byte, got.source_addr,
                                 got.signal_strength, got.is_end, got.checksum_ok);
                    end
                end
            end
        end
    end

    // Main sequence: reset, then the tests in turn, then the verdict.
    initial begin
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_rx_byte     = 8'h00;
        src_idle_pct  = 28;
        sink_idle_pct = 28;
        rx_hold_req   = 0;
        sent_bytes    = 0;
        parsed_bytes  = 0;
        stall_cycles  = 0;
        payload_beats = 0;
        end_beats     = 0;
        good_end_beats = 0;
        error_count   = 0;

        pst_phase  = afrp_pkg::PH_HUNT;
        pst_hdr    = afrp_pkg::HDR_SRC_HI;
        pst_len_hi = 8'h00;
        pst_left   = 16'd0;
        pst_sum    = 8'h00;
        pst_src    = 16'h0000;
        pst_rssi   = 8'h00;

        // The reset is synchronous, so it is held across rising edges of the clock.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_frames();
        test_back_to_back();
        test_backpressure();
        test_random_stream();

        // Let the clock run on so that any stray beat would show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d parsed), %0d cycles stalled by a full queue.",
                 sent_bytes, parsed_bytes, stall_cycles);
        $display("Checked %0d payload beats and %0d end beats (%0d good checksums).",
                 payload_beats, end_beats, good_end_beats);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d beats failed.", error_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
